@@ hdl/smt5_pkg.sv @@
// Package: widths, exponential tables and shared types for the top-5 softmax block.
package smt5_pkg;
  localparam int TopK = 5;
  localparam int MaxItems = 1024;
  localparam int LogitW = 12;
  localparam int ExpW = 32;
  localparam int IdxW = 10;
  localparam int SumW = 48;
  localparam int PctW = 23;
  localparam int RankW = 3;
  localparam int AccW = 11;
  localparam int QuotW = 24;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [22:0] PctScale = 23'd6553600;

  typedef struct packed {
    logic [ExpW-1:0] value;
    logic [IdxW-1:0] idx;
  } entry_t;

  // Carries the item that ripples down the cell row.
  // shf marks an entry pushed out by an insertion higher up: it takes the next
  // slot unconditionally, so it keeps its place ahead of equal entries below.
  typedef struct packed {
    logic            vld;
    logic            clr;
    logic            shf;
    entry_t          ent;
  } cell_ctl_t;

  function automatic logic [31:0] exp_int(input logic [3:0] a);
    logic [31:0] r;
    begin
      unique case (a)
        4'd0: r = 32'd352;        4'd1: r = 32'd956;
        4'd2: r = 32'd2599;       4'd3: r = 32'd7065;
        4'd4: r = 32'd19205;      4'd5: r = 32'd52206;
        4'd6: r = 32'd141909;     4'd7: r = 32'd385750;
        4'd8: r = 32'd1048576;    4'd9: r = 32'd2850325;
        4'd10: r = 32'd7747987;   4'd11: r = 32'd21061212;
        4'd12: r = 32'd57250310;  4'd13: r = 32'd155622477;
        4'd14: r = 32'd423025751; default: r = 32'd1149903210;
      endcase
      return r;
    end
  endfunction

  function automatic logic [17:0] exp_hi(input logic [3:0] h);
    logic [17:0] r;
    begin
      unique case (h)
        4'd0: r = 18'd65536;   4'd1: r = 18'd69763;  4'd2: r = 18'd74262;
        4'd3: r = 18'd79052;   4'd4: r = 18'd84150;  4'd5: r = 18'd89577;
        4'd6: r = 18'd95354;   4'd7: r = 18'd101504; 4'd8: r = 18'd108051;
        4'd9: r = 18'd115019;  4'd10: r = 18'd122437; 4'd11: r = 18'd130334;
        4'd12: r = 18'd138740; 4'd13: r = 18'd147688; 4'd14: r = 18'd157213;
        default: r = 18'd167352;
      endcase
      return r;
    end
  endfunction

  function automatic logic [17:0] exp_lo(input logic [3:0] l);
    logic [17:0] r;
    begin
      unique case (l)
        4'd0: r = 18'd65536;   4'd1: r = 18'd65793;  4'd2: r = 18'd66050;
        4'd3: r = 18'd66309;   4'd4: r = 18'd66568;  4'd5: r = 18'd66829;
        4'd6: r = 18'd67090;   4'd7: r = 18'd67353;  4'd8: r = 18'd67616;
        4'd9: r = 18'd67881;   4'd10: r = 18'd68147; 4'd11: r = 18'd68413;
        4'd12: r = 18'd68681;  4'd13: r = 18'd68950; 4'd14: r = 18'd69220;
        default: r = 18'd69491;
      endcase
      return r;
    end
  endfunction
endpackage

@@ hdl/smt5_cell.sv @@
// One sorted-list cell: keeps the larger entry, hands the smaller one on.
module smt5_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smt5_pkg::cell_ctl_t in_i,
  output smt5_pkg::cell_ctl_t out_o,
  output smt5_pkg::entry_t    ent_o
);
  smt5_pkg::entry_t    ent_q, ent_d;
  smt5_pkg::cell_ctl_t out_q, out_d;

  always_comb begin
    ent_d = ent_q;
    out_d = in_i;
    if (in_i.clr) begin
      ent_d = '0;
    end else if (in_i.vld && (in_i.shf || (in_i.ent.value > ent_q.value))) begin
      // Take the entry; push the held one down as a shift.
      ent_d = in_i.ent;
      out_d.ent = ent_q;
      out_d.shf = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      out_q <= '0;
    end else begin
      ent_q <= ent_d;
      out_q <= out_d;
    end
  end

  assign out_o = out_q;
  assign ent_o = ent_q;
endmodule

@@ hdl/smt5_div.sv @@
// Restoring divider: one quotient bit per cycle, rounded percent result.
module smt5_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [smt5_pkg::ExpW-1:0]   num_i,
  input  logic [smt5_pkg::SumW-1:0]   den_i,
  output logic                        done_o,
  output logic [smt5_pkg::PctW-1:0]   quot_o
);
  localparam int NumW = smt5_pkg::ExpW + 23 + 1;
  localparam int CntW = 7;
  logic [NumW-1:0]               num_q, num_d;
  logic [smt5_pkg::SumW:0]       rem_q, rem_d;
  logic [smt5_pkg::SumW-1:0]     den_q;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          run_q, run_d, done_q, done_d;
  logic [smt5_pkg::QuotW-1:0]    quo_q, quo_d;
  logic [smt5_pkg::SumW:0]       trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    trial  = {rem_q[smt5_pkg::SumW-1:0], num_q[NumW-1]};
    if (go_i) begin
      // Scale by 6553600 = 2^22 + 2^21 + 2^18 as shift-add.
      num_d = NumW'({num_i, 22'd0}) + NumW'({num_i, 21'd0}) + NumW'({num_i, 18'd0});
      rem_d = '0;
      quo_d = '0;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[smt5_pkg::QuotW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[smt5_pkg::QuotW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (go_i) den_q <= den_i;
  end

  logic [smt5_pkg::QuotW-1:0] rnd;
  // Round half up: add one where twice the remainder reaches the divisor.
  assign rnd = quo_q + ((rem_q << 1) >= {1'b0, den_q} ? 24'd1 : 24'd0);
  assign quot_o = rnd[smt5_pkg::PctW-1:0];
  assign done_o = done_q;
endmodule

@@ hdl/softmax_top5_select.sv @@
// Top level: streaming exponential, sorted top-5 cell row and percent output.
//
// Channel  | Direction | Handshake         | Payload
// request  | in        | start / busy      | logit_i, last_item_i
// result   | out       | result_valid_o    | percent_o, class_index_o, rank_o, last_result_o
//
// An ordinary request passes the accept step, one step per exponential
// product (registered per product) and one that pushes it into the cell row;
// busy covers all of these but the accept step.
// A last request then drains the row and runs one restoring division per rank;
// after the fifth result a clear step sends a clear down the cell row, then busy drops.
// Reset clears all control state and the cell row; results cannot be stalled.
module softmax_top5_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [11:0]            logit_i,
  input  logic                          last_item_i,
  output logic                          result_valid_o,
  output logic [22:0]                   percent_o,
  output logic [9:0]                    class_index_o,
  output logic [2:0]                    rank_o,
  output logic                          last_result_o
);
  localparam logic [2:0] StIdle = 3'd0, StHi = 3'd1, StLo = 3'd2, StDrain = 3'd3,
                         StDiv = 3'd4, StWait = 3'd5, StClr = 3'd6;
  localparam int K = smt5_pkg::TopK;

  logic [2:0]  st_q, st_d;
  logic        last_q;
  logic [11:0] u_q;
  logic [49:0] e_q;
  logic [smt5_pkg::SumW-1:0] sum_q, sum_d;
  logic [smt5_pkg::IdxW-1:0] cnt_q, cnt_d;
  logic [smt5_pkg::AccW-1:0] acc_q, acc_d;
  logic [2:0]  k_q, k_d;
  logic        acc_ok;
  logic [49:0] mul_in;
  logic [49:0] mul_r;
  logic [17:0] mul_f;
  logic [31:0] e_sat;
  logic        div_go, div_done;
  logic [smt5_pkg::PctW-1:0] quot;

  smt5_pkg::cell_ctl_t feed, chain [K+1];
  smt5_pkg::entry_t    ent [K];
  smt5_pkg::entry_t    sel;
  smt5_pkg::entry_t    nxt;

  assign acc_ok = (acc_q < smt5_pkg::AccW'(smt5_pkg::MaxItems));
  assign mul_in = (st_q == StHi) ? 50'(smt5_pkg::exp_int(u_q[11:8])) : e_q;
  assign mul_f  = (st_q == StHi) ? smt5_pkg::exp_hi(u_q[7:4]) : smt5_pkg::exp_lo(u_q[3:0]);
  assign mul_r  = 50'((68'(mul_in) * 68'(mul_f) + 68'd32768) >> 16);
  assign e_sat  = (e_q > 50'hFFFF_FFFF) ? 32'hFFFF_FFFF : e_q[31:0];

  always_comb begin
    st_d   = st_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    k_d    = k_q;
    div_go = 1'b0;
    feed   = '0;
    unique case (st_q)
      StIdle: if (start) st_d = acc_ok ? StHi : (last_item_i ? StDrain : StIdle);
      StHi:   st_d = StLo;
      StLo:   st_d = StWait;
      StWait: begin
        // Push the finished exponential into the cell row and the sum.
        feed.vld = 1'b1;
        feed.ent.value = e_sat;
        feed.ent.idx = cnt_q;
        sum_d = (sum_q + 48'(e_sat) < sum_q) ? smt5_pkg::SumMax : sum_q + 48'(e_sat);
        cnt_d = cnt_q + 1'b1;
        acc_d = acc_q + 1'b1;
        st_d  = last_q ? StDrain : StIdle;
        k_d   = '0;
      end
      StDrain: begin
        k_d = k_q + 1'b1;
        if (k_q == 3'(K)) begin
          k_d = '0;
          st_d = StDiv;
          div_go = 1'b1;
        end
      end
      StDiv: if (div_done) begin
        k_d = k_q + 1'b1;
        if (k_q == 3'(K - 1)) st_d = StClr;
        else div_go = 1'b1;
      end
      StClr: begin
        feed.clr = 1'b1;
        k_d = k_q + 1'b1;
        if (k_q == 3'(K)) begin
          st_d = StIdle; sum_d = '0; cnt_d = '0; acc_d = '0; k_d = '0;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; sum_q <= '0; cnt_q <= '0; acc_q <= '0; k_q <= '0; last_q <= 1'b0;
    end else begin
      st_q <= st_d; sum_q <= sum_d; cnt_q <= cnt_d; acc_q <= acc_d; k_q <= k_d;
      if (start && !busy) last_q <= last_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) u_q <= 12'(logit_i + 12'h800);
    if (st_q == StHi || st_q == StLo) e_q <= mul_r;
  end

  assign chain[0] = feed;
  for (genvar i = 0; i < K; i++) begin : g_cell
    smt5_cell u_cell (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(chain[i]),
                      .out_o(chain[i+1]), .ent_o(ent[i]));
  end

  always_comb begin
    sel = ent[0];
    for (int j = 0; j < K; j++) if (k_q == 3'(j)) sel = ent[j];
  end

  // Feed the divider the rank that the next division works on.
  always_comb begin
    nxt = ent[0];
    for (int j = 0; j < K; j++) if (k_d == 3'(j)) nxt = ent[j];
  end

  smt5_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .go_i(div_go), .num_i(nxt.value),
                  .den_i(sum_q), .done_o(div_done), .quot_o(quot));

  assign busy           = (st_q != StIdle);
  assign result_valid_o = (st_q == StDiv) && div_done;
  assign percent_o      = (sel.value == '0 || sum_q == '0) ? '0 : quot;
  assign class_index_o  = (sel.value == '0) ? '0 : sel.idx;
  assign rank_o         = k_q;
  assign last_result_o  = (k_q == 3'(K - 1));
  logic unused_chain;
  assign unused_chain = ^chain[K];
endmodule

@@ hdl/smt5_checker.sv @@
// Port-level checker for the top-5 softmax block, bound to the top level.
module smt5_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [2:0]  rank_o,
  input logic        last_result_o,
  input logic [22:0] percent_o
);
  a_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rank_o <= 3'd4)) else $error("rank out of range");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_result_o == (rank_o == 3'd4))) else $error("last mark wrong");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result while idle");
  a_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (percent_o <= 23'd6553600)) else $error("percent too large");
endmodule

bind softmax_top5_select smt5_checker u_chk (.clk_i(clk_i), .rst_ni(rst_ni),
  .start(start), .busy(busy), .result_valid_o(result_valid_o), .rank_o(rank_o),
  .last_result_o(last_result_o), .percent_o(percent_o));
